// ===== rtl/core/tsa_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsa_pkg
// Shared constants, codes and types for the team slot allocator.
// ----------------------------------------------------------------------------
package tsa_pkg;

  localparam int MAX_TEAMS = 256;
  localparam int IDX_W     = $clog2(MAX_TEAMS);
  localparam int CNT_W     = $clog2(MAX_TEAMS + 1);

  localparam int ID_W   = 15;
  localparam int SLOT_W = 8;
  localparam int POS_W  = 8;
  localparam int CMD_W  = 2;
  localparam int STAT_W = 2;
  localparam int PC_W   = (CNT_W > POS_W) ? CNT_W : POS_W;

  // commands
  localparam logic [CMD_W-1:0] CMD_ALLOC   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_RECYCLE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_LOOKUP  = 2'd2;

  // result status
  localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL   = 2'd1;
  localparam logic [STAT_W-1:0] ST_MISS   = 2'd2;
  localparam logic [STAT_W-1:0] ST_BADPOS = 2'd3;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_SEARCH,
    S_DONE
  } state_t;

  // broadcast control for the row of table cells
  typedef struct packed {
    logic             write;     // load wr_id/wr_slot into cell wr_idx
    logic             shift;     // take neighbor entry, cells from shift_lo up to count-2
    logic             cmp;       // register key compare flags
    logic [IDX_W-1:0] wr_idx;
    logic [IDX_W-1:0] shift_lo;
    logic [CNT_W-1:0] count;
    logic [IDX_W-1:0] sel;       // cell that drives its slot on sel_slot
  } cell_ctl_t;

  // free stack contents after reset: top of stack (address MAX-1) holds 0
  function automatic logic [SLOT_W-1:0] stack_reset_slot(input logic [IDX_W-1:0] addr);
    return SLOT_W'(MAX_TEAMS - 1 - int'(addr));
  endfunction

endpackage

// ===== rtl/core/team_slot_allocator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// team_slot_allocator
// LIFO slot free stack plus an id table held in a row of cells.
// ----------------------------------------------------------------------------
// Allocate, recycle, unused commands and all_team_id lookups: the beat passes
// S_EXEC and S_DONE; the next input beat is taken only back in S_IDLE.
// Searched lookup: one halving step per cycle over the registered flags, at most
// ceil(log2(table_count + 1)) steps (9 with a full table); the result then passes
// S_DONE, and the next input beat is taken only back in S_IDLE.
// A result beat held by m_tready low stalls the next item in S_DONE and the input.
// Reset (rst, synchronous): table empty, stack back to slots 255..0 with 0 on
// top via per-entry valid bits, all_team_id 0; no clearing pass.
// ----------------------------------------------------------------------------
module team_slot_allocator
  import tsa_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  // configuration: all_team_id
  input  logic              cfg_we,
  input  logic [ID_W-1:0]   cfg_wdata,
  // command beats
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [31:0]       s_tdata,   // team_id[14:0], slot_in[22:15], position[30:23], 0
  input  logic [CMD_W-1:0]  s_tuser,   // command[1:0]
  // result beats
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [15:0]       m_tdata,   // slot_out[7:0], table_position[15:8]
  output logic [STAT_W-1:0] m_tuser    // status[1:0]
);

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  state_t             state, state_next;
  logic [ID_W-1:0]    all_team_id;
  logic [CMD_W-1:0]   req_cmd;
  logic [ID_W-1:0]    req_id;
  logic [SLOT_W-1:0]  req_slot;
  logic [POS_W-1:0]   req_pos;
  logic [CNT_W-1:0]   table_count;     // free count is MAX_TEAMS - table_count
  logic [CNT_W-1:0]   lo, hi, lo_next, hi_next;
  logic [STAT_W-1:0]  res_status, res_status_next;
  logic [SLOT_W-1:0]  res_slot, res_slot_next;
  logic [POS_W-1:0]   res_pos, res_pos_next;
  logic [MAX_TEAMS-1:0] stk_valid;     // stack entry written since reset

  // --------------------------------------------------------------------------
  // Control
  // --------------------------------------------------------------------------
  logic               res_load;
  logic               out_load;
  logic               count_inc, count_dec;
  logic               ram_we;
  cell_ctl_t          ctl;

  // free stack addressing: pop at free_count-1, push at free_count
  logic [CNT_W-1:0]   pop_cnt, push_cnt;
  logic [IDX_W-1:0]   pop_addr, push_addr;
  logic [SLOT_W-1:0]  ram_rd;
  logic [SLOT_W-1:0]  got_slot;

  // binary search
  logic [CNT_W:0]     mid_sum;
  logic [CNT_W-1:0]   mid;
  logic               found;

  // cell row
  logic [ID_W-1:0]    cell_id   [MAX_TEAMS];
  logic [SLOT_W-1:0]  cell_slot [MAX_TEAMS];
  logic [SLOT_W-1:0]  cell_sel  [MAX_TEAMS];
  logic [MAX_TEAMS-1:0] lt_vec, eq_vec;
  logic [SLOT_W-1:0]  sel_slot_or;

  assign pop_cnt   = CNT_W'(MAX_TEAMS - 1) - table_count;
  assign push_cnt  = CNT_W'(MAX_TEAMS) - table_count;
  assign pop_addr  = pop_cnt[IDX_W-1:0];
  assign push_addr = push_cnt[IDX_W-1:0];

  // unwritten stack entries read as the reset order
  assign got_slot = stk_valid[pop_addr] ? ram_rd : stack_reset_slot(pop_addr);

  assign mid_sum = {1'b0, lo} + {1'b0, hi};
  assign mid     = mid_sum[CNT_W:1];
  assign found   = (lo < table_count) && eq_vec[lo[IDX_W-1:0]];

  assign s_tready = (state == S_IDLE);

  // --------------------------------------------------------------------------
  // Next state and control
  // --------------------------------------------------------------------------
  always_comb begin
    state_next      = state;
    res_load        = 1'b0;
    out_load        = 1'b0;
    count_inc       = 1'b0;
    count_dec       = 1'b0;
    ram_we          = 1'b0;
    lo_next         = lo;
    hi_next         = hi;
    res_status_next = ST_OK;
    res_slot_next   = '0;
    res_pos_next    = '0;
    ctl.write       = 1'b0;
    ctl.shift       = 1'b0;
    ctl.cmp         = 1'b0;
    ctl.wr_idx      = table_count[IDX_W-1:0];
    ctl.shift_lo    = IDX_W'(req_pos);
    ctl.count       = table_count;
    ctl.sel         = lo[IDX_W-1:0];

    unique case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          state_next = S_EXEC;
        end
      end

      S_EXEC: begin
        state_next = S_DONE;
        res_load   = 1'b1;
        case (req_cmd)
          CMD_ALLOC: begin
            if (table_count == CNT_W'(MAX_TEAMS)) begin
              res_status_next = ST_FULL;
            end else begin
              ctl.write     = 1'b1;
              count_inc     = 1'b1;
              res_slot_next = got_slot;
              res_pos_next  = POS_W'(table_count);
            end
          end
          CMD_RECYCLE: begin
            if (PC_W'(req_pos) >= PC_W'(table_count)) begin
              res_status_next = ST_BADPOS;
            end else begin
              ram_we    = 1'b1;
              ctl.shift = 1'b1;
              count_dec = 1'b1;
            end
          end
          CMD_LOOKUP: begin
            if (req_id != all_team_id) begin
              // cells latch their compare flags, search starts next cycle
              ctl.cmp    = 1'b1;
              res_load   = 1'b0;
              lo_next    = '0;
              hi_next    = table_count;
              state_next = S_SEARCH;
            end
          end
          default: begin
          end
        endcase
      end

      S_SEARCH: begin
        if (lo < hi) begin
          if (lt_vec[mid[IDX_W-1:0]]) begin
            lo_next = mid + CNT_W'(1);
          end else begin
            hi_next = mid;
          end
        end else begin
          res_load   = 1'b1;
          state_next = S_DONE;
          if (found) begin
            res_slot_next = sel_slot_or;
            res_pos_next  = POS_W'(lo);
          end else begin
            res_status_next = ST_MISS;
          end
        end
      end

      S_DONE: begin
        // wait for the output register to free up
        if (!m_tvalid || m_tready) begin
          out_load   = 1'b1;
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // --------------------------------------------------------------------------
  // Control registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      all_team_id <= '0;
      table_count <= '0;
      stk_valid   <= '0;
      m_tvalid    <= 1'b0;
    end else begin
      if (cfg_we) begin
        all_team_id <= cfg_wdata;
      end
      if (count_inc) begin
        table_count <= table_count + CNT_W'(1);
      end else if (count_dec) begin
        table_count <= table_count - CNT_W'(1);
      end
      if (ram_we) begin
        stk_valid[push_addr] <= 1'b1;
      end
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Payload registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      req_cmd  <= s_tuser;
      req_id   <= s_tdata[14:0];
      req_slot <= s_tdata[22:15];
      req_pos  <= s_tdata[30:23];
    end
    lo <= lo_next;
    hi <= hi_next;
    if (res_load) begin
      res_status <= res_status_next;
      res_slot   <= res_slot_next;
      res_pos    <= res_pos_next;
    end
    if (out_load) begin
      m_tuser <= res_status;
      m_tdata <= {res_pos, res_slot};
    end
  end

  // --------------------------------------------------------------------------
  // Free stack
  // --------------------------------------------------------------------------
  tsa_ram #(
    .WIDTH (SLOT_W),
    .DEPTH (MAX_TEAMS)
  ) u_stack (
    .clk     (clk),
    .we      (ram_we),
    .wr_addr (push_addr),
    .wr_data (req_slot),
    .rd_addr (pop_addr),
    .rd_data (ram_rd)
  );

  // --------------------------------------------------------------------------
  // Table cell row; each cell shifts in from its upper neighbor
  // --------------------------------------------------------------------------
  for (genvar i = 0; i < MAX_TEAMS; i++) begin : g_cell
    logic [ID_W-1:0]   nb_id;
    logic [SLOT_W-1:0] nb_slot;

    if (i == MAX_TEAMS - 1) begin : g_top
      assign nb_id   = '0;
      assign nb_slot = '0;
    end else begin : g_mid
      assign nb_id   = cell_id[i+1];
      assign nb_slot = cell_slot[i+1];
    end

    tsa_cell u_cell (
      .clk      (clk),
      .index    (IDX_W'(i)),
      .ctl      (ctl),
      .key      (req_id),
      .wr_id    (req_id),
      .wr_slot  (got_slot),
      .nb_id    (nb_id),
      .nb_slot  (nb_slot),
      .id       (cell_id[i]),
      .slot     (cell_slot[i]),
      .lt       (lt_vec[i]),
      .eq       (eq_vec[i]),
      .sel_slot (cell_sel[i])
    );
  end

  // only the selected cell drives a nonzero slot
  always_comb begin
    sel_slot_or = '0;
    for (int i = 0; i < MAX_TEAMS; i++) begin
      sel_slot_or = sel_slot_or | cell_sel[i];
    end
  end

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    table_count <= CNT_W'(MAX_TEAMS))
    else $error("table count beyond capacity");

  a_alloc_grows: assert property (@(posedge clk) disable iff (rst)
    (state == S_EXEC && req_cmd == CMD_ALLOC && table_count != CNT_W'(MAX_TEAMS))
    |=> table_count == $past(table_count) + CNT_W'(1))
    else $error("allocate did not grow the table");

  a_search_bounds: assert property (@(posedge clk) disable iff (rst)
    state == S_SEARCH |-> (lo <= hi && hi <= table_count))
    else $error("search window out of bounds");

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && m_tvalid && !m_tready) |=> state == S_DONE)
    else $error("pending result overrun");
`endif

endmodule

// ===== rtl/core/tsa_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsa_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module tsa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== rtl/core/tsa_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsa_cell
// One table entry: id and slot, shift from upper neighbor, key compare flags.
// ----------------------------------------------------------------------------
module tsa_cell
  import tsa_pkg::*;
(
  input  logic              clk,
  input  logic [IDX_W-1:0]  index,
  input  cell_ctl_t         ctl,
  input  logic [ID_W-1:0]   key,
  input  logic [ID_W-1:0]   wr_id,
  input  logic [SLOT_W-1:0] wr_slot,
  input  logic [ID_W-1:0]   nb_id,
  input  logic [SLOT_W-1:0] nb_slot,
  output logic [ID_W-1:0]   id,
  output logic [SLOT_W-1:0] slot,
  output logic              lt,
  output logic              eq,
  output logic [SLOT_W-1:0] sel_slot
);

  logic hit_wr;
  logic hit_shift;

  assign hit_wr    = ctl.write && (index == ctl.wr_idx);
  assign hit_shift = ctl.shift && (index >= ctl.shift_lo)
                     && ((CNT_W'(index) + CNT_W'(1)) < ctl.count);

  always_ff @(posedge clk) begin
    if (hit_wr) begin
      id   <= wr_id;
      slot <= wr_slot;
    end else if (hit_shift) begin
      id   <= nb_id;
      slot <= nb_slot;
    end
    if (ctl.cmp) begin
      lt <= (id < key);
      eq <= (id == key);
    end
  end

  assign sel_slot = (index == ctl.sel) ? slot : '0;

endmodule
